// ===== hw/rtl/gmws_pkg.sv =====
package gmws_pkg;

    localparam int MaxWidth  = 32;
    localparam int MaxHeight = 32;
    localparam int Cells     = MaxWidth * MaxHeight;
    localparam int CoordW    = $clog2(MaxWidth);
    localparam int AddrW     = $clog2(Cells);
    localparam int DimW      = 6;

    // action codes
    localparam logic [1:0] ACT_SET_WALL  = 2'd0;
    localparam logic [1:0] ACT_CAN_TRAV  = 2'd1;
    localparam logic [1:0] ACT_SOLVE     = 2'd2;
    localparam logic [1:0] ACT_READ_PATH = 2'd3;

    // register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  cell_x;
        logic [4:0]  cell_y;
        logic [1:0]  direction;
        logic        wall_present;
        logic [9:0]  step_index;
    } in_word_t;

    typedef struct packed {
        logic        travel_ok;
        logic [9:0]  path_length;
        logic [4:0]  end_column;
        logic [1:0]  step_direction;
        logic        step_valid;
    } out_word_t;

    typedef struct packed {
        logic              ok;
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
    } nbr_t;

    // clamp a size register into 1..max
    function automatic logic [DimW-1:0] used_dim(input logic [DimW-1:0] v,
                                                 input logic [DimW-1:0] vmax);
        logic [DimW-1:0] r;
        r = v;
        if (v == '0) r = DimW'(1);
        if (v > vmax) r = vmax;
        return r;
    endfunction

    // neighbor on side d, ok=0 when off the grid in use
    function automatic nbr_t neighbor(input logic [CoordW-1:0] x,
                                      input logic [CoordW-1:0] y,
                                      input logic [1:0] d,
                                      input logic [DimW-1:0] w,
                                      input logic [DimW-1:0] h);
        nbr_t n;
        n.ok = 1'b1;
        n.x  = x;
        n.y  = y;
        case (d)
            2'd0: begin
                if (({1'b0, x} + DimW'(1)) >= w) n.ok = 1'b0;
                else n.x = x + CoordW'(1);
            end
            2'd1: begin
                if (({1'b0, y} + DimW'(1)) >= h) n.ok = 1'b0;
                else n.y = y + CoordW'(1);
            end
            2'd2: begin
                if (x == '0) n.ok = 1'b0;
                else n.x = x - CoordW'(1);
            end
            default: begin
                if (y == '0) n.ok = 1'b0;
                else n.y = y - CoordW'(1);
            end
        endcase
        return n;
    endfunction

endpackage

// ===== hw/rtl/gmws_ram.sv =====
module gmws_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/grid_maze_wall_store_solver.sv =====
// Accept to result: a cell off the grid in use goes to ST_RESP, can_travel and read_path
// pass ST_CT/ST_RP, set_wall ST_SW1 (ST_SW2 too when the neighbor wall is mirrored).
// Solve: per column a clear of all 1024 visited marks plus setup and advance, then the
// walk: ST_TRY per direction, ST_VCHK when its visited mark is read, ST_LOAD per move/back.
// One word in work at a time; the next can be taken in the cycle the result is raised.
// Reset (aresetn low, synchronous) clears control; a 1024-cell pass then sets every wall.
module grid_maze_wall_store_solver (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gmws_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gmws_pkg::out_word_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int AW = gmws_pkg::AddrW;
    localparam int CW = gmws_pkg::CoordW;
    localparam int DW = gmws_pkg::DimW;
    localparam logic [DW-1:0] MaxW = DW'(gmws_pkg::MaxWidth);
    localparam logic [DW-1:0] MaxH = DW'(gmws_pkg::MaxHeight);

    typedef enum logic [12:0] {
        ST_WCLR  = 13'b0000000000001,
        ST_IDLE  = 13'b0000000000010,
        ST_SW1   = 13'b0000000000100,
        ST_SW2   = 13'b0000000001000,
        ST_CT    = 13'b0000000010000,
        ST_RP    = 13'b0000000100000,
        ST_VCLR  = 13'b0000001000000,
        ST_START = 13'b0000010000000,
        ST_LOAD  = 13'b0000100000000,
        ST_TRY   = 13'b0001000000000,
        ST_VCHK  = 13'b0010000000000,
        ST_NEXT  = 13'b0100000000000,
        ST_RESP  = 13'b1000000000000
    } state_t;

    state_t              state_reg, state_next;
    gmws_pkg::in_word_t  item_reg, item_next;
    gmws_pkg::out_word_t res_reg, res_next;
    gmws_pkg::out_word_t out_reg, out_next;
    logic                m_valid_reg, m_valid_next;
    logic [DW-1:0]       width_reg, height_reg;
    logic [AW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [CW-1:0]       x_reg, x_next, y_reg, y_next;
    logic [AW-1:0]       depth_reg, depth_next;
    logic [2:0]          try_reg, try_next;
    logic [1:0]          prev_reg, prev_next;
    logic [3:0]          walls_reg, walls_next;
    logic                back_reg, back_next;
    logic [AW-1:0]       best_len_reg, best_len_next;
    logic [CW-1:0]       best_col_reg, best_col_next;
    logic                best_sel_reg, best_sel_next;

    // memory ports
    logic          wall_we, vis_we, vis_wdata, path_we;
    logic [AW-1:0] wall_waddr, wall_raddr, vis_waddr, vis_raddr, path_waddr, path_raddr;
    logic [3:0]    wall_wdata, wall_rdata;
    logic          vis_rdata;
    logic [1:0]    path_wdata, p0_rdata, p1_rdata, work_rdata, best_rdata;

    logic [DW-1:0]  wu, hu;
    gmws_pkg::nbr_t nb_sw, nb_try, nb_back;
    logic           s_fire, blocked, at_target;

    assign wu = gmws_pkg::used_dim(width_reg, MaxW);
    assign hu = gmws_pkg::used_dim(height_reg, MaxH);
    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign work_rdata = best_sel_reg ? p0_rdata : p1_rdata;
    assign best_rdata = best_sel_reg ? p1_rdata : p0_rdata;

    assign nb_sw   = gmws_pkg::neighbor(item_reg.cell_x, item_reg.cell_y,
                                        item_reg.direction, wu, hu);
    assign nb_try  = gmws_pkg::neighbor(x_reg, y_reg, try_reg[1:0], wu, hu);
    assign nb_back = gmws_pkg::neighbor(x_reg, y_reg, prev_reg ^ 2'd2, wu, hu);

    assign blocked = walls_reg[try_reg[1:0]] || !nb_try.ok
                     || (depth_reg != '0 && try_reg[1:0] == (prev_reg ^ 2'd2));
    assign at_target = ({1'b0, nb_try.y} == hu - DW'(1)) && (nb_try.x == col_reg);

    // config registers
    assign pready = 1'b1;
    assign prdata = 32'(paddr[2] == gmws_pkg::REG_HEIGHT ? height_reg : width_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= MaxW;
            height_reg <= MaxH;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == gmws_pkg::REG_WIDTH) width_reg <= pwdata[DW-1:0];
            else height_reg <= pwdata[DW-1:0];
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg;
        cnt_next      = cnt_reg;
        col_next      = col_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        depth_next    = depth_reg;
        try_next      = try_reg;
        prev_next     = prev_reg;
        walls_next    = walls_reg;
        back_next     = back_reg;
        best_len_next = best_len_reg;
        best_col_next = best_col_reg;
        best_sel_next = best_sel_reg;

        wall_we    = 1'b0;
        wall_waddr = cnt_reg;
        wall_wdata = 4'hF;
        wall_raddr = {s_data.cell_y, s_data.cell_x};
        vis_we     = 1'b0;
        vis_waddr  = cnt_reg;
        vis_wdata  = 1'b0;
        vis_raddr  = {nb_try.y, nb_try.x};
        path_we    = 1'b0;
        path_waddr = depth_reg;
        path_wdata = try_reg[1:0];
        path_raddr = s_data.step_index;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        case (state_reg)
            ST_WCLR: begin
                wall_we  = 1'b1;
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == '1) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_fire) begin
                    item_next = s_data;
                    res_next  = '0;
                    case (s_data.action)
                        gmws_pkg::ACT_SET_WALL, gmws_pkg::ACT_CAN_TRAV: begin
                            if ({1'b0, s_data.cell_x} >= wu || {1'b0, s_data.cell_y} >= hu)
                                state_next = ST_RESP;
                            else if (s_data.action == gmws_pkg::ACT_SET_WALL)
                                state_next = ST_SW1;
                            else
                                state_next = ST_CT;
                        end
                        gmws_pkg::ACT_SOLVE: begin
                            best_len_next = '0;
                            best_col_next = '0;
                            col_next      = '0;
                            cnt_next      = '0;
                            state_next    = ST_VCLR;
                        end
                        default: state_next = ST_RP;
                    endcase
                end
            end
            ST_SW1: begin
                wall_we    = 1'b1;
                wall_waddr = {item_reg.cell_y, item_reg.cell_x};
                wall_wdata = wall_rdata;
                wall_wdata[item_reg.direction] = item_reg.wall_present;
                wall_raddr = {nb_sw.y, nb_sw.x};
                state_next = nb_sw.ok ? ST_SW2 : ST_RESP;
            end
            ST_SW2: begin
                wall_we    = 1'b1;
                wall_waddr = {nb_sw.y, nb_sw.x};
                wall_wdata = wall_rdata;
                wall_wdata[item_reg.direction ^ 2'd2] = item_reg.wall_present;
                state_next = ST_RESP;
            end
            ST_CT: begin
                res_next.travel_ok = !wall_rdata[item_reg.direction];
                state_next = ST_RESP;
            end
            ST_RP: begin
                if (item_reg.step_index < best_len_reg) begin
                    res_next.step_valid     = 1'b1;
                    res_next.step_direction = best_rdata;
                end
                state_next = ST_RESP;
            end
            // visited clear, start cell marked
            ST_VCLR: begin
                vis_we    = 1'b1;
                vis_wdata = (cnt_reg == '0);
                cnt_next  = cnt_reg + AW'(1);
                if (cnt_reg == '1) state_next = ST_START;
            end
            ST_START: begin
                wall_raddr = '0;
                if (hu == DW'(1) && col_reg == '0) begin
                    state_next = ST_NEXT;
                end else begin
                    x_next     = '0;
                    y_next     = '0;
                    depth_next = '0;
                    try_next   = '0;
                    back_next  = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                walls_next = wall_rdata;
                if (back_reg && depth_reg != '0) prev_next = work_rdata;
                state_next = ST_TRY;
            end
            ST_TRY: begin
                if (try_reg[2]) begin
                    if (depth_reg == '0) begin
                        state_next = ST_NEXT;
                    end else begin
                        // backtrack to the parent cell
                        x_next     = nb_back.x;
                        y_next     = nb_back.y;
                        depth_next = depth_reg - AW'(1);
                        try_next   = {1'b0, prev_reg} + 3'd1;
                        wall_raddr = {nb_back.y, nb_back.x};
                        path_raddr = depth_reg - AW'(2);
                        back_next  = 1'b1;
                        state_next = ST_LOAD;
                    end
                end else if (blocked) begin
                    try_next = try_reg + 3'd1;
                end else begin
                    state_next = ST_VCHK;
                end
            end
            ST_VCHK: begin
                if (vis_rdata) begin
                    try_next   = try_reg + 3'd1;
                    state_next = ST_TRY;
                end else begin
                    path_we    = 1'b1;
                    vis_we     = 1'b1;
                    vis_waddr  = {nb_try.y, nb_try.x};
                    vis_wdata  = 1'b1;
                    depth_next = depth_reg + AW'(1);
                    x_next     = nb_try.x;
                    y_next     = nb_try.y;
                    prev_next  = try_reg[1:0];
                    try_next   = '0;
                    back_next  = 1'b0;
                    wall_raddr = {nb_try.y, nb_try.x};
                    if (at_target) begin
                        if (depth_reg + AW'(1) > best_len_reg) begin
                            best_len_next = depth_reg + AW'(1);
                            best_col_next = col_reg;
                            best_sel_next = !best_sel_reg;
                        end
                        state_next = ST_NEXT;
                    end else begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_NEXT: begin
                if ({1'b0, col_reg} == wu - DW'(1)) begin
                    res_next.path_length = best_len_reg;
                    res_next.end_column  = best_col_reg;
                    state_next = ST_RESP;
                end else begin
                    col_next   = col_reg + CW'(1);
                    cnt_next   = '0;
                    state_next = ST_VCLR;
                end
            end
            // hand the result to the output register once it is free
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    out_next     = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_WCLR;
            m_valid_reg  <= 1'b0;
            cnt_reg      <= '0;
            best_len_reg <= '0;
            best_col_reg <= '0;
            best_sel_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            cnt_reg      <= cnt_next;
            best_len_reg <= best_len_next;
            best_col_reg <= best_col_next;
            best_sel_reg <= best_sel_next;
        end
        item_reg  <= item_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
        col_reg   <= col_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        depth_reg <= depth_next;
        try_reg   <= try_next;
        prev_reg  <= prev_next;
        walls_reg <= walls_next;
        back_reg  <= back_next;
    end

    gmws_ram #(.WIDTH(4), .DEPTH(gmws_pkg::Cells)) u_wall (
        .aclk(aclk), .we(wall_we), .waddr(wall_waddr), .wdata(wall_wdata),
        .raddr(wall_raddr), .rdata(wall_rdata)
    );

    gmws_ram #(.WIDTH(1), .DEPTH(gmws_pkg::Cells)) u_vis (
        .aclk(aclk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
        .raddr(vis_raddr), .rdata(vis_rdata)
    );

    // two path stores; the one not holding the best path is the work path
    gmws_ram #(.WIDTH(2), .DEPTH(gmws_pkg::Cells)) u_path0 (
        .aclk(aclk), .we(path_we && best_sel_reg), .waddr(path_waddr),
        .wdata(path_wdata), .raddr(path_raddr), .rdata(p0_rdata)
    );

    gmws_ram #(.WIDTH(2), .DEPTH(gmws_pkg::Cells)) u_path1 (
        .aclk(aclk), .we(path_we && !best_sel_reg), .waddr(path_waddr),
        .wdata(path_wdata), .raddr(path_raddr), .rdata(p1_rdata)
    );

    // checks
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("accepted a word while busy");

    a_rise_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_RESP))
        else $error("result raised outside response state");

    a_backtrack_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TRY && try_reg[2] && depth_reg != '0)
        |=> depth_reg == $past(depth_reg) - AW'(1))
        else $error("backtrack did not pop one step");

    a_best_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && best_len_reg != $past(best_len_reg))
        |-> (best_len_reg > $past(best_len_reg) || best_len_reg == '0))
        else $error("kept path length shrank during solve");

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 400000;
    localparam logic [2:0] ADDR_W = 3'(4 * gmws_pkg::REG_WIDTH);
    localparam logic [2:0] ADDR_H = 3'(4 * gmws_pkg::REG_HEIGHT);

    // wall sides
    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_UP    = 2'd3;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    gmws_pkg::in_word_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    gmws_pkg::out_word_t m_data;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    grid_maze_wall_store_solver uut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow copy of the block state
    logic [3:0] walls [gmws_pkg::Cells];
    logic [1:0] trail [gmws_pkg::Cells];
    logic [1:0] kept  [gmws_pkg::Cells];
    bit         seen  [gmws_pkg::Cells];
    logic [2:0] next_try [gmws_pkg::Cells + 1];
    logic [5:0] reg_w = 6'd32, reg_h = 6'd32;
    int         kept_len = 0, kept_col = 0;

    gmws_pkg::out_word_t pending_words [$];
    int         errors = 0;
    int         results_seen = 0;
    bit         calm = 1'b0;

    function automatic int clamp_dim(logic [5:0] v, int vmax);
        int r;
        r = int'(v);
        if (r == 0) r = 1;
        if (r > vmax) r = vmax;
        return r;
    endfunction

    function automatic bit step_to(int x, int y, int d, int w, int h,
                                   output int nx, output int ny);
        nx = x;
        ny = y;
        case (d)
            DIR_RIGHT: begin if (x + 1 >= w) return 0; nx = x + 1; end
            DIR_DOWN:  begin if (y + 1 >= h) return 0; ny = y + 1; end
            DIR_LEFT:  begin if (x == 0) return 0; nx = x - 1; end
            default:   begin if (y == 0) return 0; ny = y - 1; end
        endcase
        return 1;
    endfunction

    // depth-first walk from the origin to (col, h-1); -1 when unreachable
    function automatic int walk_to(int col, int w, int h);
        int x, y, depth, d, nx, ny;
        bit moved;
        x = 0; y = 0; depth = 0;
        foreach (seen[i]) seen[i] = 0;
        seen[0] = 1;
        if (y == h - 1 && x == col) return 0;
        next_try[0] = 0;
        forever begin
            moved = 0;
            while (next_try[depth] < 4 && !moved) begin
                d = int'(next_try[depth]);
                next_try[depth] = 3'(d + 1);
                if (walls[y * gmws_pkg::MaxWidth + x][d]) continue;
                if (depth > 0 && trail[depth - 1] == 2'(d + 2)) continue;
                if (!step_to(x, y, d, w, h, nx, ny)) continue;
                if (seen[ny * gmws_pkg::MaxWidth + nx]) continue;
                if (depth >= gmws_pkg::Cells) continue;
                trail[depth] = 2'(d);
                depth++;
                next_try[depth] = 0;
                x = nx; y = ny;
                seen[y * gmws_pkg::MaxWidth + x] = 1;
                moved = 1;
            end
            if (moved) begin
                if (y == h - 1 && x == col) return depth;
                continue;
            end
            if (depth == 0) return -1;
            depth--;
            void'(step_to(x, y, int'(2'(trail[depth] + 2'd2)), w, h, nx, ny));
            x = nx; y = ny;
        end
    endfunction

    function automatic gmws_pkg::out_word_t maze_answer(gmws_pkg::in_word_t wd);
        gmws_pkg::out_word_t o;
        int w, h, nx, ny, len;
        o = '0;
        w = clamp_dim(reg_w, gmws_pkg::MaxWidth);
        h = clamp_dim(reg_h, gmws_pkg::MaxHeight);
        case (wd.action)
            gmws_pkg::ACT_SET_WALL: begin
                if (int'(wd.cell_x) < w && int'(wd.cell_y) < h) begin
                    walls[wd.cell_y * gmws_pkg::MaxWidth + wd.cell_x][wd.direction] =
                        wd.wall_present;
                    if (step_to(int'(wd.cell_x), int'(wd.cell_y), int'(wd.direction),
                                w, h, nx, ny))
                        walls[ny * gmws_pkg::MaxWidth + nx][2'(wd.direction + 2'd2)] =
                            wd.wall_present;
                end
            end
            gmws_pkg::ACT_CAN_TRAV: begin
                if (int'(wd.cell_x) < w && int'(wd.cell_y) < h)
                    o.travel_ok =
                        !walls[wd.cell_y * gmws_pkg::MaxWidth + wd.cell_x][wd.direction];
            end
            gmws_pkg::ACT_SOLVE: begin
                kept_len = 0;
                kept_col = 0;
                for (int c = 0; c < w; c++) begin
                    len = walk_to(c, w, h);
                    if (len > 0 && len > kept_len) begin
                        kept_len = len;
                        kept_col = c;
                        for (int i = 0; i < len; i++) kept[i] = trail[i];
                    end
                end
                o.path_length = kept_len > 1023 ? 10'd1023 : 10'(kept_len);
                o.end_column = 5'(kept_col);
            end
            default: begin
                if (int'(wd.step_index) < kept_len) begin
                    o.step_direction = kept[wd.step_index];
                    o.step_valid = 1'b1;
                end
            end
        endcase
        return o;
    endfunction

    function automatic int idle_draw();
        if (calm) return 0;
        return int'($urandom_range(0, 14));
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    // result checker
    always @(posedge aclk) begin
        gmws_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_words.size() == 0) begin
                report("unexpected word", int'(m_data), 0);
            end else begin
                want = pending_words.pop_front();
                if (m_data.travel_ok != want.travel_ok)
                    report("travel_ok", int'(m_data.travel_ok), int'(want.travel_ok));
                if (m_data.path_length != want.path_length)
                    report("path_length", int'(m_data.path_length),
                           int'(want.path_length));
                if (m_data.end_column != want.end_column)
                    report("end_column", int'(m_data.end_column), int'(want.end_column));
                if (m_data.step_direction != want.step_direction)
                    report("step_direction", int'(m_data.step_direction),
                           int'(want.step_direction));
                if (m_data.step_valid != want.step_valid)
                    report("step_valid", int'(m_data.step_valid), int'(want.step_valid));
            end
        end
    end

    // receiver stalls, redrawn after every word taken
    always @(negedge aclk) begin
        static int taken = 0;
        static int hold = 0;
        if (results_seen != taken) begin
            taken = results_seen;
            hold = idle_draw();
        end
        if (hold > 0) begin
            hold--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        static int quiet = 0;
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_word(gmws_pkg::in_word_t wd);
        int gap;
        gap = idle_draw();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= wd;
        do @(posedge aclk); while (!s_ready);
        pending_words = {pending_words, maze_answer(wd)};
    endtask

    task automatic send_fields(logic [1:0] act, int x, int y, logic [1:0] d,
                               bit present, int idx);
        gmws_pkg::in_word_t wd;
        wd.action = act;
        wd.cell_x = 5'(x);
        wd.cell_y = 5'(y);
        wd.direction = d;
        wd.wall_present = present;
        wd.step_index = 10'(idx);
        send_word(wd);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] a, logic [31:0] v);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= v;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_grid(int w, int h);
        wait_idle();
        apb_write(ADDR_W, 32'(w));
        reg_w = 6'(w);
        apb_write(ADDR_H, 32'(h));
        reg_h = 6'(h);
    endtask

    // random spanning tree over the grid, sent as wall openings
    task automatic carve_tree(int w, int h);
        bit in_tree [gmws_pkg::Cells];
        int stack_x [$], stack_y [$];
        int x, y, nx, ny, d, opts [$];
        foreach (in_tree[i]) in_tree[i] = 0;
        stack_x = {stack_x, 0};
        stack_y = {stack_y, 0};
        in_tree[0] = 1;
        while (stack_x.size() != 0) begin
            x = stack_x[$];
            y = stack_y[$];
            opts.delete();
            for (int k = 0; k < 4; k++)
                if (step_to(x, y, k, w, h, nx, ny) && !in_tree[ny * gmws_pkg::MaxWidth + nx])
                    opts = {opts, k};
            if (opts.size() == 0) begin
                void'(stack_x.pop_back());
                void'(stack_y.pop_back());
                continue;
            end
            d = opts[$urandom_range(0, opts.size() - 1)];
            void'(step_to(x, y, d, w, h, nx, ny));
            in_tree[ny * gmws_pkg::MaxWidth + nx] = 1;
            send_fields(gmws_pkg::ACT_SET_WALL, x, y, 2'(d), 1'b0, 0);
            stack_x = {stack_x, nx};
            stack_y = {stack_y, ny};
        end
    endtask

    // after reset every wall stands and no path exists
    task automatic test_reset_walls();
        calm = 1'b1;
        send_fields(gmws_pkg::ACT_CAN_TRAV, 0, 0, DIR_RIGHT, 1'b0, 0);
        send_fields(gmws_pkg::ACT_CAN_TRAV, 31, 31, DIR_DOWN, 1'b0, 0);
        send_fields(gmws_pkg::ACT_CAN_TRAV, 31, 0, DIR_LEFT, 1'b0, 0);
        send_fields(gmws_pkg::ACT_CAN_TRAV, 0, 31, DIR_UP, 1'b0, 0);
        send_fields(gmws_pkg::ACT_READ_PATH, 0, 0, DIR_RIGHT, 1'b0, 0);
        send_fields(gmws_pkg::ACT_SOLVE, 0, 0, DIR_RIGHT, 1'b0, 0);
        // open wall on the border stays inside the grid
        send_fields(gmws_pkg::ACT_SET_WALL, 31, 31, DIR_RIGHT, 1'b0, 0);
        send_fields(gmws_pkg::ACT_CAN_TRAV, 31, 31, DIR_RIGHT, 1'b0, 0);
        calm = 1'b0;
    endtask

    // size registers at and beyond their limits
    task automatic test_size_extremes();
        set_grid(0, 63);
        // outside the clamped grid: ignored write, zero answer
        send_fields(gmws_pkg::ACT_SET_WALL, 1, 0, DIR_LEFT, 1'b0, 0);
        send_fields(gmws_pkg::ACT_CAN_TRAV, 1, 0, DIR_LEFT, 1'b0, 0);
        send_fields(gmws_pkg::ACT_CAN_TRAV, 0, 0, DIR_RIGHT, 1'b0, 0);
        send_fields(gmws_pkg::ACT_SET_WALL, 0, 31, DIR_UP, 1'b0, 0);
        send_fields(gmws_pkg::ACT_SET_WALL, 0, 0, DIR_DOWN, 1'b0, 0);
        set_grid(1, 1);
        // start equals target: zero length, nothing kept
        send_fields(gmws_pkg::ACT_SOLVE, 0, 0, DIR_RIGHT, 1'b0, 0);
        send_fields(gmws_pkg::ACT_READ_PATH, 0, 0, DIR_RIGHT, 1'b0, 0);
        set_grid(4, 1);
        send_fields(gmws_pkg::ACT_SET_WALL, 0, 0, DIR_RIGHT, 1'b0, 0);
        send_fields(gmws_pkg::ACT_SET_WALL, 2, 0, DIR_LEFT, 1'b0, 0);
        send_fields(gmws_pkg::ACT_SET_WALL, 2, 0, DIR_RIGHT, 1'b0, 0);
        send_fields(gmws_pkg::ACT_CAN_TRAV, 3, 0, DIR_LEFT, 1'b0, 0);
        send_fields(gmws_pkg::ACT_SOLVE, 0, 0, DIR_RIGHT, 1'b0, 0);
        send_fields(gmws_pkg::ACT_READ_PATH, 0, 0, DIR_RIGHT, 1'b0, 0);
        send_fields(gmws_pkg::ACT_READ_PATH, 0, 0, DIR_RIGHT, 1'b0, 2);
        send_fields(gmws_pkg::ACT_READ_PATH, 0, 0, DIR_RIGHT, 1'b0, 3);
        send_fields(gmws_pkg::ACT_READ_PATH, 31, 31, DIR_UP, 1'b1, 1023);
        // close again so one column drops out
        send_fields(gmws_pkg::ACT_SET_WALL, 3, 0, DIR_LEFT, 1'b1, 0);
        send_fields(gmws_pkg::ACT_SOLVE, 0, 0, DIR_RIGHT, 1'b0, 0);
    endtask

    // carved maze followed by mixed random words
    task automatic test_random_maze(int w, int h, int n);
        int uw, uh, r, x, y, idx;
        set_grid(w, h);
        uw = clamp_dim(6'(w), gmws_pkg::MaxWidth);
        uh = clamp_dim(6'(h), gmws_pkg::MaxHeight);
        calm = ($urandom_range(0, 2) == 0);
        carve_tree(uw, uh);
        send_fields(gmws_pkg::ACT_SOLVE, 0, 0, DIR_RIGHT, 1'b0, 0);
        calm = 1'b0;
        for (int i = 0; i < n; i++) begin
            r = int'($urandom_range(0, 99));
            if ($urandom_range(0, 9) == 0) begin
                x = int'($urandom_range(0, 31));
                y = int'($urandom_range(0, 31));
            end else begin
                x = int'($urandom_range(0, uw - 1));
                y = int'($urandom_range(0, uh - 1));
            end
            if ($urandom_range(0, 3) == 0) idx = int'($urandom_range(0, 1023));
            else idx = int'($urandom_range(0, kept_len + 1));
            if (r < 35)
                send_fields(gmws_pkg::ACT_SET_WALL, x, y, 2'($urandom_range(0, 3)),
                            1'($urandom_range(0, 1)), idx);
            else if (r < 55)
                send_fields(gmws_pkg::ACT_CAN_TRAV, x, y, 2'($urandom_range(0, 3)),
                            1'($urandom_range(0, 1)), idx);
            else if (r < 65)
                send_fields(gmws_pkg::ACT_SOLVE, x, y, 2'($urandom_range(0, 3)),
                            1'($urandom_range(0, 1)), idx);
            else
                send_fields(gmws_pkg::ACT_READ_PATH, x, y, 2'($urandom_range(0, 3)),
                            1'($urandom_range(0, 1)), idx);
        end
    endtask

    initial begin
        foreach (walls[i]) walls[i] = 4'hF;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_walls();
        test_size_extremes();
        test_random_maze(4, 4, 8);
        test_random_maze(1, 6, 8);
        test_random_maze(6, 5, 8);
        test_random_maze(40, 1, 8);

        wait_idle();
        repeat (50) @(posedge aclk);
        if (errors == 0 && pending_words.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/gmws_pkg.sv
hw/rtl/gmws_ram.sv
hw/rtl/grid_maze_wall_store_solver.sv
tb/tb.sv
